>>> rtl/core/kvt_pkg.sv
`timescale 1ns / 1ps

package kvt_pkg;

    localparam logic [7:0] ESCAPE_BYTE    = 8'd92;
    localparam logic [7:0] KEY_SEP_RESET  = 8'd61;
    localparam logic [7:0] PAIR_SEP_RESET = 8'd59;

    localparam logic CFG_KEY_SEP  = 1'b0;
    localparam logic CFG_PAIR_SEP = 1'b1;

    typedef enum logic [2:0] {
        MODE_KEY_SKIP    = 3'd0,
        MODE_KEY_COLLECT = 3'd1,
        MODE_VAL_SKIP    = 3'd2,
        MODE_VAL_COLLECT = 3'd3,
        MODE_STOPPED     = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        KIND_KEY_CHAR = 3'd0,
        KIND_VAL_CHAR = 3'd1,
        KIND_KEY_END  = 3'd2,
        KIND_PAIR_END = 3'd3,
        KIND_DONE     = 3'd4
    } t_kind;

    // main result of one byte, besides flushed whitespace and end marks
    typedef enum logic [1:0] {
        MAIN_NONE     = 2'd0,
        MAIN_CHAR     = 2'd1,
        MAIN_KEY_END  = 2'd2,
        MAIN_PAIR_END = 2'd3
    } t_main;

    typedef enum logic [2:0] {
        STEP_FLUSH    = 3'd0,
        STEP_MAIN     = 3'd1,
        STEP_KEY_END  = 3'd2,
        STEP_PAIR_END = 3'd3,
        STEP_DONE     = 3'd4
    } t_step;

    typedef struct packed {
        logic  accept;
        logic  emit;
        t_step step;
        logic  last;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic flush_pending;
        logic flush_last;
        logic plan_flush;
        logic plan_main;
        logic plan_key_end;
        logic plan_pair_end;
        logic plan_done;
    } t_status;

    function automatic logic is_ws(input logic [7:0] c);
        return c inside {[8'd9:8'd13], 8'd32};
    endfunction

endpackage

>>> rtl/core/kvt_datapath.sv
`timescale 1ns / 1ps

module kvt_datapath #(
    parameter int HELD_CAP = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr_en,
    input  logic [0:0]     i_cfg_addr,
    input  logic [7:0]     i_cfg_wr_data,
    input  logic [7:0]     i_char,
    input  logic           i_end,
    input  kvt_pkg::t_cmd  i_cmd,
    output kvt_pkg::t_status o_status,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic [7:0]     o_out_char,
    output logic [2:0]     o_out_kind,
    output logic           o_out_last,
    output logic           o_out_ovf
);
    import kvt_pkg::*;

    localparam int CW = $clog2(HELD_CAP + 1);
    localparam int IW = (HELD_CAP > 1) ? $clog2(HELD_CAP) : 1;

    logic [7:0]    r_key_sep;
    logic [7:0]    r_pair_sep;
    t_mode         r_mode;
    logic          r_esc;
    logic [CW-1:0] r_cnt;
    logic          r_khc;
    logic          r_ovf;
    logic [7:0]    r_held [HELD_CAP];

    logic [CW-1:0] r_flush_n;
    logic [CW-1:0] r_rd_idx;
    t_main         r_main;
    logic [7:0]    r_char;
    t_kind         r_char_kind;
    logic          r_item_ovf;

    logic          r_out_valid;
    logic [7:0]    r_out_char;
    t_kind         r_out_kind;
    logic          r_out_last;
    logic          r_out_ovf;

    t_mode         n_mode;
    logic          n_esc;
    logic [CW-1:0] n_cnt;
    logic          n_khc;
    logic          n_ovf;

    t_mode         m1;
    logic          active;
    logic          key;
    logic          ws;
    logic [7:0]    sep;
    logic          d_flush;
    logic          d_store;
    t_main         d_main;
    t_kind         d_char_kind;
    logic          fin_key_end;
    logic          fin_pair_end;
    logic [7:0]    e_char;
    t_kind         e_kind;

    // decode of the byte at the input against the current parse state
    always_comb begin
        ws          = is_ws(i_char);
        n_mode      = r_mode;
        n_esc       = r_esc;
        n_cnt       = r_cnt;
        n_khc       = r_khc;
        n_ovf       = r_ovf;
        d_flush     = 1'b0;
        d_store     = 1'b0;
        d_main      = MAIN_NONE;
        m1          = r_mode;
        active      = 1'b0;
        if (r_mode == MODE_KEY_SKIP || r_mode == MODE_VAL_SKIP) begin
            if (!ws) begin
                active = 1'b1;
                m1 = (r_mode == MODE_KEY_SKIP) ? MODE_KEY_COLLECT : MODE_VAL_COLLECT;
            end
        end else if (r_mode == MODE_KEY_COLLECT || r_mode == MODE_VAL_COLLECT) begin
            active = 1'b1;
        end
        key         = (m1 == MODE_KEY_COLLECT);
        sep         = key ? r_key_sep : r_pair_sep;
        d_char_kind = key ? KIND_KEY_CHAR : KIND_VAL_CHAR;
        if (active) begin
            n_mode = m1;
            if (!r_esc && i_char == sep) begin
                n_cnt = '0;
                n_esc = 1'b0;
                if (key) begin
                    if (r_khc) begin
                        d_main = MAIN_KEY_END;
                        n_mode = MODE_VAL_SKIP;
                    end else begin
                        n_mode = MODE_STOPPED;
                    end
                end else begin
                    d_main = MAIN_PAIR_END;
                    n_mode = MODE_KEY_SKIP;
                    n_khc  = 1'b0;
                end
            end else if (!r_esc && i_char == ESCAPE_BYTE) begin
                d_flush = 1'b1;
                n_esc   = 1'b1;
            end else if (r_esc) begin
                d_flush = 1'b1;
                d_main  = MAIN_CHAR;
                n_esc   = 1'b0;
            end else if (ws) begin
                if (r_cnt < CW'(HELD_CAP)) begin
                    d_store = 1'b1;
                    n_cnt   = r_cnt + CW'(1);
                end else begin
                    n_ovf = 1'b1;
                end
            end else begin
                d_flush = 1'b1;
                d_main  = MAIN_CHAR;
            end
            if (d_flush) begin
                n_cnt = '0;
            end
            if (key && ((d_flush && r_cnt != '0) || d_main == MAIN_CHAR)) begin
                n_khc = 1'b1;
            end
        end
        fin_key_end  = i_end && n_mode == MODE_KEY_COLLECT && n_khc;
        fin_pair_end = fin_key_end ||
                       (i_end && (n_mode == MODE_VAL_SKIP || n_mode == MODE_VAL_COLLECT));
    end

    always_comb begin
        o_status.out_free      = !r_out_valid || i_out_ready;
        o_status.flush_pending = (r_rd_idx != r_flush_n);
        o_status.flush_last    = (CW'(r_rd_idx + CW'(1)) == r_flush_n);
        o_status.plan_flush    = d_flush && (r_cnt != '0);
        o_status.plan_main     = (d_main != MAIN_NONE);
        o_status.plan_key_end  = fin_key_end;
        o_status.plan_pair_end = fin_pair_end;
        o_status.plan_done     = i_end;
    end

    // payload of the beat the controller asks for
    always_comb begin
        e_char = 8'd0;
        e_kind = KIND_DONE;
        case (i_cmd.step)
            STEP_FLUSH: begin
                e_char = r_held[r_rd_idx[IW-1:0]];
                e_kind = r_char_kind;
            end
            STEP_MAIN: begin
                case (r_main)
                    MAIN_CHAR: begin
                        e_char = r_char;
                        e_kind = r_char_kind;
                    end
                    MAIN_KEY_END:  e_kind = KIND_KEY_END;
                    MAIN_PAIR_END: e_kind = KIND_PAIR_END;
                    default:       e_kind = KIND_DONE;
                endcase
            end
            STEP_KEY_END:  e_kind = KIND_KEY_END;
            STEP_PAIR_END: e_kind = KIND_PAIR_END;
            default:       e_kind = KIND_DONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_sep   <= KEY_SEP_RESET;
            r_pair_sep  <= PAIR_SEP_RESET;
            r_mode      <= MODE_KEY_SKIP;
            r_esc       <= 1'b0;
            r_cnt       <= '0;
            r_khc       <= 1'b0;
            r_ovf       <= 1'b0;
            r_flush_n   <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_KEY_SEP:  r_key_sep  <= i_cfg_wr_data;
                    CFG_PAIR_SEP: r_pair_sep <= i_cfg_wr_data;
                    default:      r_key_sep  <= r_key_sep;
                endcase
            end
            if (i_cmd.accept) begin
                if (i_end) begin
                    r_mode <= MODE_KEY_SKIP;
                    r_esc  <= 1'b0;
                    r_cnt  <= '0;
                    r_khc  <= 1'b0;
                    r_ovf  <= 1'b0;
                end else begin
                    r_mode <= n_mode;
                    r_esc  <= n_esc;
                    r_cnt  <= n_cnt;
                    r_khc  <= n_khc;
                    r_ovf  <= n_ovf;
                end
                r_flush_n <= d_flush ? r_cnt : '0;
                r_rd_idx  <= '0;
            end else if (i_cmd.emit && i_cmd.step == STEP_FLUSH) begin
                r_rd_idx <= r_rd_idx + CW'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            if (d_store) begin
                r_held[r_cnt[IW-1:0]] <= i_char;
            end
            r_main      <= d_main;
            r_char      <= i_char;
            r_char_kind <= d_char_kind;
            r_item_ovf  <= n_ovf;
        end
        if (i_cmd.emit) begin
            r_out_char <= e_char;
            r_out_kind <= e_kind;
            r_out_last <= i_cmd.last;
            r_out_ovf  <= r_item_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_kind  = r_out_kind;
    assign o_out_last  = r_out_last;
    assign o_out_ovf   = r_out_ovf;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(HELD_CAP))
        else $error("held count beyond capacity");

    a_rd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_idx <= r_flush_n)
        else $error("flush read pointer past flush length");

    a_stopped_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_STOPPED |-> (!r_esc && r_cnt == '0))
        else $error("stopped mode with pending escape or held whitespace");

endmodule

>>> rtl/core/kvt_ctrl.sv
`timescale 1ns / 1ps

module kvt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  kvt_pkg::t_status i_status,
    output kvt_pkg::t_cmd    o_cmd
);
    import kvt_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_BUSY
    } t_state;

    t_state     r_state;
    t_state     n_state;
    // pending steps: main, key end, pair end, done (lowest bit first)
    logic [3:0] r_todo;
    logic [3:0] n_todo;
    logic       plan_any;

    always_comb begin
        o_cmd    = '{accept: 1'b0, emit: 1'b0, step: STEP_DONE, last: 1'b0};
        n_state  = r_state;
        n_todo   = r_todo;
        plan_any = i_status.plan_flush | i_status.plan_main | i_status.plan_key_end
                 | i_status.plan_pair_end | i_status.plan_done;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_todo = {i_status.plan_done, i_status.plan_pair_end,
                              i_status.plan_key_end, i_status.plan_main};
                    n_state = plan_any ? S_BUSY : S_IDLE;
                end
            end
            S_BUSY: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.flush_pending) begin
                        o_cmd.step = STEP_FLUSH;
                        o_cmd.last = i_status.flush_last && (r_todo == 4'd0);
                    end else if (r_todo[0]) begin
                        o_cmd.step = STEP_MAIN;
                        o_cmd.last = (r_todo[3:1] == 3'd0);
                        n_todo[0]  = 1'b0;
                    end else if (r_todo[1]) begin
                        o_cmd.step = STEP_KEY_END;
                        o_cmd.last = (r_todo[3:2] == 2'd0);
                        n_todo[1]  = 1'b0;
                    end else if (r_todo[2]) begin
                        o_cmd.step = STEP_PAIR_END;
                        o_cmd.last = !r_todo[3];
                        n_todo[2]  = 1'b0;
                    end else begin
                        o_cmd.step = STEP_DONE;
                        o_cmd.last = 1'b1;
                        n_todo[3]  = 1'b0;
                    end
                    if (o_cmd.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_todo  <= 4'd0;
        end else begin
            r_state <= n_state;
            r_todo  <= n_todo;
        end
    end

    a_busy_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_BUSY |-> (r_todo != 4'd0 || i_status.flush_pending))
        else $error("busy with nothing left to send");

    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (i_status.out_free && !o_cmd.accept))
        else $error("beat loaded into a full output register");

endmodule

>>> rtl/core/key_value_tokenizer.sv
// a byte that yields results is accepted in the idle state; its result beats (flushed whitespace,
//   char or mark, end marks) are then loaded one at a time into the single output register
//   from the busy state, each only while that register is free; a byte with no result is just taken
// a new byte is taken once all beats of the previous one are in the output register
// reset: synchronous, active low; separators return to '=' and ';', parsing to key start
`timescale 1ns / 1ps

module key_value_tokenizer #(
    parameter int HELD_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [0:0] i_cfg_addr,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // in_char
    input  logic       s_axis_tlast,   // in_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // out_char
    output logic [3:0] m_axis_tuser,   // out_kind [2:0], out_overflow [3]
    output logic       m_axis_tlast    // out_last
);
    import kvt_pkg::*;

    localparam int HELD_CAP = (HELD_DEPTH < 16) ? HELD_DEPTH : 16;

    t_cmd       cmd;
    t_status    status;
    logic [2:0] out_kind;
    logic       out_ovf;

    kvt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    kvt_datapath #(
        .HELD_CAP (HELD_CAP)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_char        (s_axis_tdata),
        .i_end         (s_axis_tlast),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_char    (m_axis_tdata),
        .o_out_kind    (out_kind),
        .o_out_last    (m_axis_tlast),
        .o_out_ovf     (out_ovf)
    );

    assign m_axis_tuser = {out_ovf, out_kind};

endmodule

>>> bench/tb_key_value_tokenizer.sv
`timescale 1ns / 1ps

module tb_key_value_tokenizer;
    import kvt_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HELD_SLOTS  = 16;

    typedef struct {
        logic [7:0] ch;
        t_kind      kind;
        logic       last;
        logic       ovf;
    } t_token;

    // mirrors the tokenizer state and holds the result beats still owed by the block
    class t_kv_scoreboard;
        logic [7:0] key_sep;
        logic [7:0] pair_sep;
        t_mode      mode;
        bit         esc_pending;
        logic [7:0] held_ws [HELD_SLOTS];
        int         held_n;
        bit         key_seen;
        bit         ws_dropped;
        t_token     tokens_due[$];
        t_token     step_tokens[$];
        int         errors;
        int         beats_checked;
        int         ovf_beats;

        function new();
            key_sep       = KEY_SEP_RESET;
            pair_sep      = PAIR_SEP_RESET;
            errors        = 0;
            beats_checked = 0;
            ovf_beats     = 0;
            clear_string();
        endfunction

        function void write_reg(logic idx, logic [7:0] val);
            if (idx == CFG_KEY_SEP) begin
                key_sep = val;
            end else begin
                pair_sep = val;
            end
        endfunction

        function void clear_string();
            mode        = MODE_KEY_SKIP;
            esc_pending = 0;
            held_n      = 0;
            key_seen    = 0;
            ws_dropped  = 0;
        endfunction

        function bit is_blank(logic [7:0] c);
            return (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
        endfunction

        function void add(logic [7:0] ch, t_kind k);
            t_token t;
            t.ch   = ch;
            t.kind = k;
            t.last = 0;
            t.ovf  = 0;
            step_tokens.insert(step_tokens.size(), t);
        endfunction

        function void add_char(logic [7:0] c);
            if (mode == MODE_KEY_COLLECT) begin
                add(c, KIND_KEY_CHAR);
                key_seen = 1;
            end else begin
                add(c, KIND_VAL_CHAR);
            end
        endfunction

        function void release_held();
            for (int i = 0; i < held_n; i++) add_char(held_ws[i]);
            held_n = 0;
        endfunction

        function void parse_byte(logic [7:0] c);
            logic [7:0] sep;
            if (mode == MODE_STOPPED) return;
            if (mode == MODE_KEY_SKIP || mode == MODE_VAL_SKIP) begin
                if (is_blank(c)) return;
                mode = (mode == MODE_KEY_SKIP) ? MODE_KEY_COLLECT : MODE_VAL_COLLECT;
            end
            sep = (mode == MODE_KEY_COLLECT) ? key_sep : pair_sep;
            if (!esc_pending && c == sep) begin
                // field end: trailing whitespace is dropped
                held_n = 0;
                if (mode == MODE_KEY_COLLECT) begin
                    if (key_seen) begin
                        add(8'd0, KIND_KEY_END);
                        mode = MODE_VAL_SKIP;
                    end else begin
                        mode = MODE_STOPPED;
                    end
                end else begin
                    add(8'd0, KIND_PAIR_END);
                    mode     = MODE_KEY_SKIP;
                    key_seen = 0;
                end
            end else if (!esc_pending && c == ESCAPE_BYTE) begin
                release_held();
                esc_pending = 1;
            end else if (esc_pending) begin
                release_held();
                add_char(c);
                esc_pending = 0;
            end else if (is_blank(c)) begin
                if (held_n < HELD_SLOTS) begin
                    held_ws[held_n] = c;
                    held_n++;
                end else begin
                    ws_dropped = 1;
                end
            end else begin
                release_held();
                add_char(c);
            end
        endfunction

        function void note_byte(logic [7:0] c, logic e);
            step_tokens.delete();
            parse_byte(c);
            if (e) begin
                case (mode)
                    MODE_KEY_COLLECT: begin
                        if (key_seen) begin
                            add(8'd0, KIND_KEY_END);
                            add(8'd0, KIND_PAIR_END);
                        end
                    end
                    MODE_VAL_SKIP, MODE_VAL_COLLECT: begin
                        add(8'd0, KIND_PAIR_END);
                    end
                    default: begin
                    end
                endcase
                add(8'd0, KIND_DONE);
            end
            foreach (step_tokens[i]) step_tokens[i].ovf = ws_dropped;
            if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1;
            foreach (step_tokens[i]) tokens_due.insert(tokens_due.size(), step_tokens[i]);
            if (e) clear_string();
        endfunction

        function void compare(string what, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= 50)
                    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            end
        endfunction

        function void check_beat(logic [7:0] ch, logic [2:0] kind, logic ovf, logic last);
            t_token want;
            if (tokens_due.size() == 0) begin
                errors++;
                if (errors <= 50)
                    $display("%0t: beat with none expected, expected nothing, got char %0d kind %0d",
                             $time, ch, kind);
                return;
            end
            want = tokens_due.pop_front();
            beats_checked++;
            if (want.ovf) ovf_beats++;
            compare("out_char", want.ch, ch);
            compare("out_kind", 8'(want.kind), 8'(kind));
            compare("out_overflow", 8'(want.ovf), 8'(ovf));
            compare("out_last", 8'(want.last), 8'(last));
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_wr_en = 1'b0;
    logic [0:0] i_cfg_addr = 1'b0;
    logic [7:0] i_cfg_wr_data = 8'd0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'd0;   // in_char
    logic       s_axis_tlast = 1'b0;   // in_end
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b1;
    logic [7:0] m_axis_tdata;          // out_char
    logic [3:0] m_axis_tuser;          // out_kind [2:0], out_overflow [3]
    logic       m_axis_tlast;          // out_last

    t_kv_scoreboard sb = new();
    bit           idle_on = 1;
    int           cycle_count = 0;
    int           n_bytes = 0;
    int           n_strings = 0;
    int           n_settings = 1;
    logic [7:0]   string_bytes[$];

    key_value_tokenizer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready = !idle_on || ($urandom_range(0, 99) >= 6);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tdata, m_axis_tuser[2:0], m_axis_tuser[3], m_axis_tlast);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d beats outstanding", $time, sb.tokens_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] c, input logic e);
        @(negedge i_clk);
        while (idle_on && $urandom_range(0, 99) < 6) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = c;
        s_axis_tlast  = e;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_byte(c, e);
        n_bytes++;
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        s_axis_tlast  = 1'b0;
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_addr    = idx;
        i_cfg_wr_data = val;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        sb.write_reg(idx, val);
    endtask

    // every owed beat seen, plus slack for a byte that yields nothing
    task automatic drain();
        while (sb.tokens_due.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    function automatic void append_byte(logic [7:0] b);
        string_bytes.insert(string_bytes.size(), b);
    endfunction

    function automatic logic [7:0] ws_byte();
        int r;
        r = $urandom_range(9, 14);
        return (r == 14) ? 8'd32 : 8'(r);
    endfunction

    function automatic void add_blanks(int n);
        for (int i = 0; i < n; i++) append_byte(ws_byte());
    endfunction

    function automatic void add_field();
        int r;
        int len;
        if ($urandom_range(0, 99) < 50) add_blanks($urandom_range(1, 3));
        len = $urandom_range(0, 6);
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                append_byte(8'($urandom_range(97, 122)));
            end else if (r < 75) begin
                // a long run overruns the whitespace store
                add_blanks(($urandom_range(0, 99) < 8) ? $urandom_range(17, 20)
                                                       : $urandom_range(1, 3));
            end else if (r < 87) begin
                append_byte(ESCAPE_BYTE);
                append_byte(8'($urandom_range(0, 255)));
            end else begin
                append_byte(8'($urandom_range(0, 255)));
            end
        end
        r = $urandom_range(0, 99);
        if (r < 10) add_blanks($urandom_range(17, 20));
        else if (r < 55) add_blanks($urandom_range(1, 3));
    endfunction

    task automatic send_random_string();
        int pairs;
        int cut;
        string_bytes.delete();
        pairs = $urandom_range(1, 3);
        for (int p = 0; p < pairs; p++) begin
            if ($urandom_range(0, 99) >= 5) add_field();
            append_byte(sb.key_sep);
            add_field();
            if (p < pairs - 1 || $urandom_range(0, 1)) append_byte(sb.pair_sep);
        end
        if ($urandom_range(0, 99) < 10) begin
            cut = $urandom_range(1, string_bytes.size());
            string_bytes = string_bytes[0:cut-1];
        end
        if ($urandom_range(0, 99) < 5) append_byte(ESCAPE_BYTE);
        foreach (string_bytes[i]) send_byte(string_bytes[i], i == string_bytes.size() - 1);
        n_strings++;
    endtask

    task automatic run_strings(input int target);
        int start;
        start = n_bytes;
        while (n_bytes - start < target) send_random_string();
        stop_sending();
        drain();
    endtask

    initial begin
        logic [7:0] key_list [6];
        logic [7:0] pair_list [6];
        key_list  = '{8'd0,   8'd255, ESCAPE_BYTE, 8'd32,       8'd44, KEY_SEP_RESET};
        pair_list = '{8'd255, 8'd0,   8'd32,       ESCAPE_BYTE, 8'd38, PAIR_SEP_RESET};

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed pass on the reset separators
        send_byte(8'd32, 0);            // leading blank skipped
        send_byte("k", 0);
        send_byte(8'd32, 0);            // held
        send_byte(ESCAPE_BYTE, 0);      // releases the held blank
        send_byte(KEY_SEP_RESET, 0);    // escaped separator is a key char
        send_byte(8'h00, 0);
        send_byte(8'd32, 0);
        send_byte(KEY_SEP_RESET, 0);    // key end, trailing blank dropped
        send_byte(8'd9, 0);
        send_byte(8'hff, 0);
        send_byte(ESCAPE_BYTE, 0);
        send_byte(ESCAPE_BYTE, 0);      // escaped backslash
        send_byte(8'd13, 0);
        send_byte(PAIR_SEP_RESET, 0);
        send_byte(KEY_SEP_RESET, 0);    // empty key stops parsing
        send_byte("x", 0);
        send_byte(PAIR_SEP_RESET, 1);   // only done
        send_byte("a", 1);              // key end, pair end and done together
        send_byte("b", 0);
        send_byte(KEY_SEP_RESET, 1);    // empty value at end of string
        send_byte(ESCAPE_BYTE, 1);      // escape left pending at the end
        send_byte(8'd32, 1);
        stop_sending();
        drain();

        run_strings(35);
        for (int s = 0; s < 6; s++) begin
            write_reg(CFG_KEY_SEP, key_list[s]);
            write_reg(CFG_PAIR_SEP, pair_list[s]);
            n_settings++;
            idle_on = (s != 4);
            run_strings(30);
        end
        idle_on = 1;

        $display("sent %0d bytes in %0d strings across %0d separator settings",
                 n_bytes, n_strings, n_settings);
        $display("checked %0d result beats, %0d of them flagged overflow",
                 sb.beats_checked, sb.ovf_beats);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
